@@ hw/rtl/ovl_pkg.sv @@
`timescale 1ns / 1ps

package ovl_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 32;
    localparam int MODE_W       = 2;
    localparam int STATUS_W     = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND   = 2'd0,
        MODE_REMOVE   = 2'd1,
        MODE_TRAVERSE = 2'd2
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_TRAV,
        S_RESP
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic    capture;    // latch the incoming value, rewind the pointer
        logic    append_wr;  // write value at tail, count + 1
        logic    count_dec;  // count - 1 at end of a removal
        logic    rd_issue;   // read entry at pointer, pointer + 1
        logic    rd_keep;    // hold read data that was not consumed
        logic    shift_wr;   // write read data one slot down
        logic    out_load;   // load the output register
        logic    out_data;   // entry field from read data, else zero
        t_status out_status;
        logic    out_last;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic count_zero;
        logic count_full;
        logic rd_vld;
        logic match;
        logic ptr_end;
        logic out_free;
    } t_dp_stat;

endpackage

@@ hw/rtl/ovl_ctrl.sv @@
`timescale 1ns / 1ps

module ovl_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [ovl_pkg::MODE_W-1:0]    i_in_mode,
    output logic                          o_in_ready,
    input  ovl_pkg::t_dp_stat             i_stat,
    output ovl_pkg::t_cmd                 o_cmd
);

    ovl_pkg::t_state  r_state, n_state;
    ovl_pkg::t_status r_resp,  n_resp;
    logic             accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ovl_pkg::S_IDLE;
            r_resp  <= ovl_pkg::ST_DONE;
        end else begin
            r_state <= n_state;
            r_resp  <= n_resp;
        end
    end

    assign o_in_ready = (r_state == ovl_pkg::S_IDLE);
    assign accept     = o_in_ready && i_in_valid;

    always_comb begin
        n_state = r_state;
        n_resp  = r_resp;
        o_cmd   = '0;
        o_cmd.out_status = ovl_pkg::ST_DONE;
        unique case (r_state)
            ovl_pkg::S_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    unique case (i_in_mode)
                        ovl_pkg::MODE_APPEND: begin
                            if (i_stat.count_full) begin
                                n_resp = ovl_pkg::ST_FULL;
                            end else begin
                                o_cmd.append_wr = 1'b1;
                                n_resp          = ovl_pkg::ST_DONE;
                            end
                            n_state = ovl_pkg::S_RESP;
                        end
                        ovl_pkg::MODE_REMOVE: begin
                            if (i_stat.count_zero) begin
                                n_resp  = ovl_pkg::ST_EMPTY;
                                n_state = ovl_pkg::S_RESP;
                            end else begin
                                n_state = ovl_pkg::S_SEARCH;
                            end
                        end
                        ovl_pkg::MODE_TRAVERSE: begin
                            if (i_stat.count_zero) begin
                                n_resp  = ovl_pkg::ST_EMPTY;
                                n_state = ovl_pkg::S_RESP;
                            end else begin
                                n_state = ovl_pkg::S_TRAV;
                            end
                        end
                        default: n_state = ovl_pkg::S_IDLE;  // unused mode, no result
                    endcase
                end
            end
            ovl_pkg::S_SEARCH: begin
                // read data is registered, so it lags the pointer
                if (i_stat.rd_vld && i_stat.match) begin
                    n_state = ovl_pkg::S_SHIFT;
                end else if (i_stat.rd_vld && i_stat.ptr_end) begin
                    n_resp  = ovl_pkg::ST_NOT_FOUND;
                    n_state = ovl_pkg::S_RESP;
                end else begin
                    o_cmd.rd_issue = !i_stat.ptr_end;
                end
            end
            ovl_pkg::S_SHIFT: begin
                o_cmd.shift_wr = i_stat.rd_vld;
                o_cmd.rd_issue = !i_stat.ptr_end;
                if (i_stat.ptr_end) begin
                    o_cmd.count_dec = 1'b1;
                    n_resp          = ovl_pkg::ST_DONE;
                    n_state         = ovl_pkg::S_RESP;
                end
            end
            ovl_pkg::S_TRAV: begin
                o_cmd.out_load = i_stat.rd_vld && i_stat.out_free;
                o_cmd.out_data = 1'b1;
                o_cmd.out_last = i_stat.ptr_end;
                o_cmd.rd_keep  = !i_stat.out_free;
                o_cmd.rd_issue = !i_stat.ptr_end && (!i_stat.rd_vld || i_stat.out_free);
                if (o_cmd.out_load && i_stat.ptr_end) begin
                    n_state = ovl_pkg::S_IDLE;
                end
            end
            ovl_pkg::S_RESP: begin
                o_cmd.out_status = r_resp;
                o_cmd.out_last   = 1'b1;
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ovl_pkg::S_IDLE;
                end
            end
            default: n_state = ovl_pkg::S_IDLE;
        endcase
    end

    // a traverse or a search only runs over a non-empty list
    a_walk_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ovl_pkg::S_TRAV || r_state == ovl_pkg::S_SEARCH) |-> !i_stat.count_zero)
        else $error("walk over empty list");

    // every accepted append goes straight to its single response
    a_single_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_mode == ovl_pkg::MODE_APPEND) |=> (r_state == ovl_pkg::S_RESP))
        else $error("append did not go to response");

    a_remove_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_mode == ovl_pkg::MODE_REMOVE && !i_stat.count_zero)
        |=> (r_state == ovl_pkg::S_SEARCH))
        else $error("remove did not start a search");

endmodule

@@ hw/rtl/ovl_dpath.sv @@
`timescale 1ns / 1ps

module ovl_dpath #(
    parameter int CAPACITY = ovl_pkg::CAPACITY_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ovl_pkg::t_cmd                   i_cmd,
    output ovl_pkg::t_dp_stat               o_stat,
    input  logic [ovl_pkg::VALUE_W-1:0]     i_value,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [ovl_pkg::STATUS_W-1:0]    o_out_status,
    output logic [ovl_pkg::VALUE_W-1:0]     o_out_entry,
    output logic                            o_out_last
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    logic [ovl_pkg::VALUE_W-1:0] mem [CAPACITY];

    logic [ovl_pkg::VALUE_W-1:0]  r_value;
    logic [CW-1:0]                r_count, n_count;
    logic [CW-1:0]                r_ptr,   n_ptr;
    logic                         r_rd_vld, n_rd_vld;
    logic [IW-1:0]                r_cmp_idx;
    logic [ovl_pkg::VALUE_W-1:0]  r_rd_data;
    logic                         r_out_valid, n_out_valid;
    logic [ovl_pkg::STATUS_W-1:0] r_out_status;
    logic [ovl_pkg::VALUE_W-1:0]  r_out_entry;
    logic                         r_out_last;

    logic                         wr_en;
    logic [IW-1:0]                wr_addr;
    logic [ovl_pkg::VALUE_W-1:0]  wr_data;
    logic                         out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // single write port: tail on append, one slot down while compacting
    always_comb begin
        wr_en   = i_cmd.append_wr || i_cmd.shift_wr;
        wr_addr = i_cmd.append_wr ? r_count[IW-1:0] : (r_cmp_idx - 1'b1);
        wr_data = i_cmd.append_wr ? i_value : r_rd_data;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= mem[r_ptr[IW-1:0]];
            r_cmp_idx <= r_ptr[IW-1:0];
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.append_wr) begin
            n_count = r_count + 1'b1;
        end else if (i_cmd.count_dec) begin
            n_count = r_count - 1'b1;
        end
        n_ptr = r_ptr;
        if (i_cmd.capture) begin
            n_ptr = '0;
        end else if (i_cmd.rd_issue) begin
            n_ptr = r_ptr + 1'b1;
        end
        n_rd_vld = i_cmd.rd_issue || (i_cmd.rd_keep && r_rd_vld);
        if (i_cmd.capture) begin
            n_rd_vld = 1'b0;
        end
        n_out_valid = i_cmd.out_load || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ptr       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_ptr       <= n_ptr;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_value <= i_value;
        end
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_status;
            r_out_entry  <= i_cmd.out_data ? r_rd_data : '0;
            r_out_last   <= i_cmd.out_last;
        end
    end

    always_comb begin
        o_stat.count_zero = (r_count == '0);
        o_stat.count_full = (r_count == CW'(CAPACITY));
        o_stat.rd_vld     = r_rd_vld;
        o_stat.match      = (r_rd_data == r_value);
        o_stat.ptr_end    = (r_ptr == r_count);
        o_stat.out_free   = out_free;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_entry  = r_out_entry;
    assign o_out_last   = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("count above capacity");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !i_cmd.out_load)
        else $error("output register overwritten while stalled");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_issue |-> (r_ptr < r_count))
        else $error("read past the last entry");

    a_shift_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.shift_wr |-> (r_rd_vld && r_cmp_idx != '0 && !i_cmd.append_wr))
        else $error("compaction write without read data");

endmodule

@@ hw/rtl/ordered_value_list.sv @@
`timescale 1ns / 1ps
// Ordered list of signed 32-bit values, up to CAPACITY entries.
// Input channel s_axis: tuser carries the mode (append, remove first match,
// traverse), tdata the value. Output channel m_axis: tuser carries the
// status (done/element, not found, empty, full), tdata the entry during a
// traverse (zero otherwise), tlast marks the final result of an item.
// One item is worked at a time; s_axis_tready is high only between items.
// Append: 1 result.
// Remove: 1 result after a scan of the entries up to the first match and a
//   compaction of the entries behind it, one entry per cycle.
// Traverse: count results (one empty status when the list is empty), one
//   entry per cycle once started, while the receiver takes them.
// The rate is set by the single read port of the entry memory.
// Reset empties the list; entry memory is not cleared and needs no sweep.
// When the receiver stalls, the result waits in the output register and
// the walk pauses with it; nothing is dropped.
module ordered_value_list #(
    parameter int CAPACITY = ovl_pkg::CAPACITY_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [ovl_pkg::VALUE_W-1:0]     s_axis_tdata,   // [31:0] value
    input  logic [ovl_pkg::MODE_W-1:0]      s_axis_tuser,   // [1:0] mode
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [ovl_pkg::VALUE_W-1:0]     m_axis_tdata,   // [31:0] entry
    output logic [ovl_pkg::STATUS_W-1:0]    m_axis_tuser,   // [1:0] status
    output logic                            m_axis_tlast
);

    ovl_pkg::t_cmd     cmd;
    ovl_pkg::t_dp_stat stat;

    ovl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_mode  (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ovl_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_value      (s_axis_tdata),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_status (m_axis_tuser),
        .o_out_entry  (m_axis_tdata),
        .o_out_last   (m_axis_tlast)
    );

endmodule

@@ verif/ovl_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of ordered_value_list, keeps its own copy of the
// list and compares every result transfer with the oldest prediction.
module ovl_checker #(
    parameter int CAPACITY = ovl_pkg::CAPACITY_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [ovl_pkg::VALUE_W-1:0]     i_in_value,
    input  logic [ovl_pkg::MODE_W-1:0]      i_in_mode,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [ovl_pkg::VALUE_W-1:0]     i_out_entry,
    input  logic [ovl_pkg::STATUS_W-1:0]    i_out_status,
    input  logic                            i_out_last,
    output int                              o_err_cnt,
    output int                              o_pending
);

    typedef struct packed {
        ovl_pkg::t_status             status;
        logic [ovl_pkg::VALUE_W-1:0]  entry;
        logic                         last;
    } t_list_result;

    logic [ovl_pkg::VALUE_W-1:0] list_vals [CAPACITY];
    int                          list_len  = 0;
    t_list_result                results_due[$];
    int                          err_total = 0;

    function automatic void queue_result(ovl_pkg::t_status status,
                                         logic [ovl_pkg::VALUE_W-1:0] entry,
                                         logic last);
        t_list_result r;
        r.status = status;
        r.entry  = entry;
        r.last   = last;
        results_due.push_back(r);
    endfunction

    // Apply one accepted item to the shadow list and queue what it must produce.
    function automatic void predict_item(logic [ovl_pkg::MODE_W-1:0] mode,
                                         logic [ovl_pkg::VALUE_W-1:0] value);
        int hit;
        hit = -1;
        case (mode)
            ovl_pkg::MODE_APPEND: begin
                if (list_len >= CAPACITY) begin
                    queue_result(ovl_pkg::ST_FULL, '0, 1'b1);
                end else begin
                    list_vals[list_len] = value;
                    list_len++;
                    queue_result(ovl_pkg::ST_DONE, '0, 1'b1);
                end
            end
            ovl_pkg::MODE_REMOVE: begin
                if (list_len == 0) begin
                    queue_result(ovl_pkg::ST_EMPTY, '0, 1'b1);
                end else begin
                    for (int i = 0; i < list_len; i++)
                        if (hit < 0 && list_vals[i] == value) hit = i;
                    if (hit < 0) begin
                        queue_result(ovl_pkg::ST_NOT_FOUND, '0, 1'b1);
                    end else begin
                        // close the gap behind the removed entry
                        for (int j = hit; j + 1 < list_len; j++)
                            list_vals[j] = list_vals[j + 1];
                        list_len--;
                        queue_result(ovl_pkg::ST_DONE, '0, 1'b1);
                    end
                end
            end
            ovl_pkg::MODE_TRAVERSE: begin
                if (list_len == 0) begin
                    queue_result(ovl_pkg::ST_EMPTY, '0, 1'b1);
                end else begin
                    for (int i = 0; i < list_len; i++)
                        queue_result(ovl_pkg::ST_DONE, list_vals[i], i == list_len - 1);
                end
            end
            default: ;  // unused mode: no result, list untouched
        endcase
    endfunction

    always @(posedge i_clk) begin : watch
        t_list_result got;
        t_list_result want;
        if (!i_rst_n) begin
            list_len = 0;
            results_due.delete();
        end else begin
            // results first, so an item taken in this cycle cannot pair with them
            if (i_out_valid && i_out_ready) begin
                got = {i_out_status, i_out_entry, i_out_last};
                if (results_due.size() == 0) begin
                    err_total++;
                    if (err_total <= 10)
                        $display("%t: unexpected result: status %0d entry %h last %0d",
                                 $realtime, i_out_status, i_out_entry, i_out_last);
                end else begin
                    want = results_due.pop_front();
                    if (got.status !== want.status || got.entry !== want.entry ||
                        got.last !== want.last) begin
                        err_total++;
                        if (err_total <= 10)
                            $display({"%t: result mismatch (expected/actual): ",
                                      "status %0d/%0d entry %h/%h last %0d/%0d"},
                                     $realtime, want.status, i_out_status,
                                     want.entry, i_out_entry, want.last, i_out_last);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                predict_item(i_in_mode, i_in_value);
        end
        o_err_cnt <= err_total;
        o_pending <= results_due.size();
    end

endmodule

@@ verif/tb_ordered_value_list.sv @@
`timescale 1ns / 1ps

module tb_ordered_value_list;

    localparam logic [ovl_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 435;
    localparam int PHASE_LEN    = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;

    localparam logic [ovl_pkg::VALUE_W-1:0] VALUE_POOL [8] = '{
        32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000,
        32'h7FFF_FFFF, 32'h0000_0005, 32'h0000_0100, 32'hA5A5_5A5A
    };

    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [ovl_pkg::VALUE_W-1:0]     s_axis_tdata  = '0;   // [31:0] value
    logic [ovl_pkg::MODE_W-1:0]      s_axis_tuser  = '0;   // [1:0] mode
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [ovl_pkg::VALUE_W-1:0]     m_axis_tdata;         // [31:0] entry
    logic [ovl_pkg::STATUS_W-1:0]    m_axis_tuser;         // [1:0] status
    logic                            m_axis_tlast;

    int   err_cnt;
    int   pending;
    int   cycle_cnt    = 0;
    int   rx_stall_pct = 25;
    int   stall_left   = 0;
    int   hold_left    = 0;
    logic hold_req     = 1'b0;
    logic hold_done    = 1'b0;
    logic fast_phase   = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    ordered_value_list dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    ovl_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_value   (s_axis_tdata),
        .i_in_mode    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_entry  (m_axis_tdata),
        .i_out_status (m_axis_tuser),
        .i_out_last   (m_axis_tlast),
        .o_err_cnt    (err_cnt),
        .o_pending    (pending)
    );

    // mostly short idle stretches, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 93) return $urandom_range(3, 6);
        return $urandom_range(10, 30);
    endfunction

    function automatic int tx_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        return idle_len();
    endfunction

    // pool values make removals hit; single-bit flips give near misses
    function automatic logic [ovl_pkg::VALUE_W-1:0] pick_value(logic draining);
        int r;
        r = $urandom_range(0, 99);
        if (r < (draining ? 80 : 50)) return VALUE_POOL[$urandom_range(0, 7)];
        if (r < (draining ? 88 : 65))
            return VALUE_POOL[$urandom_range(0, 7)] ^ (32'd1 << $urandom_range(0, 31));
        return $urandom();
    endfunction

    // Receiver: random stalls, plus one long hold-off so the block backs up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_left     <= HOLD_CYCLES - 1;
            hold_done     <= 1'b1;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < rx_stall_pct) begin
            stall_left    <= idle_len() - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Valid stays high between back-to-back items; it only drops for a gap.
    task automatic send_item(input logic [ovl_pkg::MODE_W-1:0] mode,
                             input logic [ovl_pkg::VALUE_W-1:0] value);
        int gap;
        gap = fast_phase ? 0 : tx_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= value;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    initial begin
        int                         done_items;
        int                         next_phase_at;
        int                         phase;
        int                         r;
        logic                       filling;
        logic [ovl_pkg::MODE_W-1:0] mode;

        done_items    = 0;
        next_phase_at = 0;
        phase         = 0;
        filling       = 1'b1;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list cases
        send_item(ovl_pkg::MODE_TRAVERSE, 32'h0000_0000);
        send_item(ovl_pkg::MODE_REMOVE, VALUE_POOL[3]);
        // fill up with extremes first and a repeated value
        for (int k = 0; k < 16; k++)
            send_item(ovl_pkg::MODE_APPEND,
                      (k == 0) ? VALUE_POOL[3] : (k == 1) ? VALUE_POOL[4] :
                      (k == 2) ? VALUE_POOL[0] : (k == 3) ? VALUE_POOL[2] :
                      (k % 5 == 4) ? VALUE_POOL[5] : $urandom());
        send_item(ovl_pkg::MODE_APPEND, 32'h1234_5678);   // full
        send_item(ovl_pkg::MODE_TRAVERSE, $urandom());
        send_item(ovl_pkg::MODE_REMOVE, 32'h7FFF_FFFE);   // one bit off: no match
        send_item(ovl_pkg::MODE_REMOVE, VALUE_POOL[5]);   // first of the repeats
        send_item(ovl_pkg::MODE_REMOVE, VALUE_POOL[3]);   // head
        send_item(MODE_UNUSED, VALUE_POOL[4]);
        send_item(ovl_pkg::MODE_TRAVERSE, 32'h0000_0000);

        hold_req <= 1'b1;

        while (done_items < RANDOM_ITEMS) begin
            if (done_items == next_phase_at) begin
                next_phase_at += PHASE_LEN;
                filling    = (phase % 2 == 0);
                fast_phase = ($urandom_range(0, 3) == 0);
                rx_stall_pct <= fast_phase ? 0 : $urandom_range(10, 40);
                phase++;
            end
            r = $urandom_range(0, 99);
            if (r < 5)
                mode = MODE_UNUSED;
            else if (r < (filling ? 60 : 25))
                mode = ovl_pkg::MODE_APPEND;
            else if (r < 80)
                mode = ovl_pkg::MODE_REMOVE;
            else
                mode = ovl_pkg::MODE_TRAVERSE;
            send_item(mode, pick_value(!filling));
            done_items++;
        end
        s_axis_tvalid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
